[hw/rtl/gcm_pkg.sv]
// Shared types and constants for the greedy change maker.
// Holds the two denomination tables and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package gcm_pkg;

	localparam int AMOUNT_W = 24;
	localparam int DENOM_W  = 17;
	localparam int INDEX_W  = 4;
	localparam int SLOTS    = 16;
	localparam int QCNT_W   = 5;

	localparam logic [INDEX_W-1:0] PLN_LAST = 4'd14;
	localparam logic [INDEX_W-1:0] USD_LAST = 4'd13;

	localparam logic CUR_PLN = 1'b0;
	localparam logic CUR_USD = 1'b1;

	localparam logic [DENOM_W-1:0] PLN_TABLE [0:SLOTS-1] = '{
		17'd50000, 17'd20000, 17'd10000, 17'd5000, 17'd2000, 17'd1000, 17'd500, 17'd200,
		17'd100, 17'd50, 17'd20, 17'd10, 17'd5, 17'd2, 17'd1, 17'd0
	};
	localparam logic [DENOM_W-1:0] USD_TABLE [0:SLOTS-1] = '{
		17'd100000, 17'd20000, 17'd10000, 17'd5000, 17'd2000, 17'd1000, 17'd500, 17'd200,
		17'd100, 17'd50, 17'd25, 17'd10, 17'd5, 17'd1, 17'd0, 17'd0
	};

	function automatic logic [DENOM_W-1:0] denom_lookup(input logic cur,
			input logic [INDEX_W-1:0] idx);
		denom_lookup = (cur == CUR_USD) ? USD_TABLE[idx] : PLN_TABLE[idx];
	endfunction

	// controller -> datapath
	typedef struct packed {
		logic load;      // take a new amount, restart the walk
		logic start_div; // latch denomination, clear divider
		logic div_step;  // one quotient bit
		logic next_idx;  // advance table index
		logic emit;      // write result register, update remainder
	} gcm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic amount_zero;
		logic rem_zero;
		logic fits;
		logic idx_end;
		logic div_last;
		logic out_free;
	} gcm_stat_t;

endpackage

`default_nettype wire

[hw/rtl/gcm_ctrl.sv]
// Walk sequencer for the greedy change maker.
// One-hot state machine issuing gcm_cmd_t; depends on gcm_pkg.
`default_nettype none

module gcm_ctrl import gcm_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_fire,
	output logic       in_ready,
	input  gcm_stat_t  stat,
	output gcm_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_OUT   = 4'b1000
	} gcm_state_t;

	gcm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					if (!stat.amount_zero) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.rem_zero) begin
					state_d = ST_IDLE;
				end else if (stat.fits) begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIV;
				end else if (stat.idx_end) begin
					state_d = ST_IDLE;
				end else begin
					cmd.next_idx = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					// datapath flags the final result through idx_end/last logic
					if (stat.idx_end) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_idx = 1'b1;
						state_d      = ST_CHECK;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/gcm_dp.sv]
// Datapath of the greedy change maker: remainder, table index,
// restoring divider and result register. Depends on gcm_pkg.
`default_nettype none

module gcm_dp import gcm_pkg::*; #(
	parameter int NUM_DENOMS = 15
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       currency,
	input  wire  [AMOUNT_W-1:0]       amount,
	input  gcm_cmd_t                  cmd,
	output gcm_stat_t                 stat,
	output logic                      out_valid,
	input  wire                       out_taken,
	output logic [DENOM_W-1:0]        out_denom,
	output logic [AMOUNT_W-1:0]       out_count,
	output logic                      out_last
);

	localparam logic [INDEX_W-1:0] NUM_M1 = INDEX_W'(NUM_DENOMS - 1);

	logic [AMOUNT_W-1:0] rem_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [DENOM_W-1:0]  dsr_q;
	logic [DENOM_W-1:0]  part_q;
	logic [AMOUNT_W-1:0] dvd_q;
	logic [QCNT_W-1:0]   qcnt_q;
	logic                out_valid_q;
	logic [DENOM_W-1:0]  out_denom_q;
	logic [AMOUNT_W-1:0] out_count_q;
	logic                out_last_q;

	logic [INDEX_W-1:0]  limit_m1;
	logic [DENOM_W-1:0]  cur_denom;
	logic [DENOM_W-1:0]  tail_denom;
	logic [DENOM_W:0]    trial;
	logic                trial_ge;
	logic                is_last;

	always_comb begin
		if (currency == CUR_USD) begin
			limit_m1 = (NUM_M1 < USD_LAST) ? NUM_M1 : USD_LAST;
		end else begin
			limit_m1 = (NUM_M1 < PLN_LAST) ? NUM_M1 : PLN_LAST;
		end
	end

	assign cur_denom  = denom_lookup(currency, idx_q);
	assign tail_denom = denom_lookup(currency, limit_m1);

	assign trial    = {part_q, dvd_q[AMOUNT_W-1]};
	assign trial_ge = (trial >= {1'b0, dsr_q});

	// table is descending: nothing later fits once the remainder drops below
	// the smallest entry still inside the walk
	assign is_last = (idx_q == limit_m1) || (part_q < tail_denom);

	assign stat.amount_zero = (amount == '0);
	assign stat.rem_zero    = (rem_q == '0);
	assign stat.fits        = (cur_denom != '0) && ({7'd0, cur_denom} <= rem_q);
	assign stat.idx_end     = cmd.emit ? is_last : (idx_q == limit_m1);
	assign stat.div_last    = (qcnt_q == QCNT_W'(AMOUNT_W - 1));
	assign stat.out_free    = !out_valid_q || out_taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			idx_q  <= '0;
			qcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				rem_q <= amount;
				idx_q <= '0;
			end else begin
				if (cmd.emit) rem_q <= {7'd0, part_q};
				if (cmd.next_idx) idx_q <= idx_q + 1'b1;
			end
			if (cmd.start_div) begin
				qcnt_q <= '0;
			end else if (cmd.div_step) begin
				qcnt_q <= qcnt_q + 1'b1;
			end
		end
	end

	// restoring divider, one quotient bit per cycle; quotient shifts into dvd_q
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			dsr_q  <= cur_denom;
			part_q <= '0;
			dvd_q  <= rem_q;
		end else if (cmd.div_step) begin
			part_q <= trial_ge ? DENOM_W'(trial - {1'b0, dsr_q}) : trial[DENOM_W-1:0];
			dvd_q  <= {dvd_q[AMOUNT_W-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_denom_q <= dsr_q;
			out_count_q <= dvd_q;
			out_last_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_denom = out_denom_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/greedy_change_maker.sv]
// Greedy change maker, top level: stream ports, APB register, ctrl + datapath.
// Depends on gcm_pkg, gcm_ctrl, gcm_dp.
//
//  channel   dir  signals                       transfer carries
//  s_axis    in   s_tvalid/s_tready/s_tdata     amount [23:0]
//  m_axis    out  m_tvalid/m_tready/m_tdata     denomination [16:0], count [40:17]
//                 m_tlast                       last result of an amount
//  apb       in   psel/penable/pwrite/paddr     currency at 0x0 (bit 0)
//
// An amount is accepted, then the walk scans the table entry by entry
// and, for each denomination paid, runs the bit-serial divider and then
// the result write; a new amount is taken once the walk ends.
// A stalled m_tready holds the walk at the result write; the result register
// lets the walk finish and the next amount enter while the last result waits.
// Reset is asynchronous and clears control state and the currency register.
`default_nettype none

module greedy_change_maker import gcm_pkg::*; #(
	parameter int NUM_DENOMS = 15
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [23:0] amount
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // [16:0] denomination, [40:17] count, zero fill
	output logic        m_tlast,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic              currency_q;
	gcm_cmd_t          cmd;
	gcm_stat_t         stat;
	logic              in_fire;
	logic [DENOM_W-1:0]  out_denom;
	logic [AMOUNT_W-1:0] out_count;

	assign pready = 1'b1;

	// one register: index is paddr[2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			currency_q <= CUR_PLN;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			currency_q <= pwdata[0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : {31'd0, currency_q};

	assign in_fire = s_tvalid && s_tready;

	gcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gcm_dp #(
		.NUM_DENOMS (NUM_DENOMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.currency  (currency_q),
		.amount    (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_taken (m_tready),
		.out_denom (out_denom),
		.out_count (out_count),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'd0, out_count, out_denom};

endmodule

`default_nettype wire

[hw/rtl/gcm_checker.sv]
// Port-level checks for greedy_change_maker, attached by bind.
// No dependencies beyond the top level's ports.
`default_nettype none

module gcm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [47:0] m_tdata,
	input wire        m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_denom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16:0] != 17'd0)
		else $error("zero denomination");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40:17] != 24'd0)
		else $error("zero count");

	// an idle input side stays ready until a transfer happens
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("ready dropped without a transfer");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:41] == 7'd0)
		else $error("nonzero fill bits");

endmodule

bind greedy_change_maker gcm_checker u_gcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

[tb/greedy_change_maker_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for greedy_change_maker: drives amounts on the input stream,
// predicts each payout from its own denomination tables, and checks the output stream.
// Depends on gcm_pkg and greedy_change_maker.

module greedy_change_maker_tb;
	import gcm_pkg::*;

	localparam int NUM_DENOMS    = 15;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 500;
	localparam int RANDOM_ITEMS  = 34;    // per idling phase
	localparam int MAX_PRINTED   = 200;

	localparam logic [2:0] REG_CURRENCY = 3'd0;
	localparam logic [2:0] REG_UNMAPPED = 3'd4;

	typedef struct packed {
		logic [16:0] denom;
		logic [23:0] count;
		logic        last;
	} payout_t;

	class payout_checker;
		payout_t due_payouts[$];
		int      mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		static function logic [16:0] coin_value(input logic cur, input int slot);
			logic [16:0] v;
			v = '0;
			if (cur == CUR_USD) begin
				case (slot)
					0: v = 17'd100000;
					1: v = 17'd20000;
					2: v = 17'd10000;
					3: v = 17'd5000;
					4: v = 17'd2000;
					5: v = 17'd1000;
					6: v = 17'd500;
					7: v = 17'd200;
					8: v = 17'd100;
					9: v = 17'd50;
					10: v = 17'd25;
					11: v = 17'd10;
					12: v = 17'd5;
					13: v = 17'd1;
					default: v = '0;
				endcase
			end else begin
				case (slot)
					0: v = 17'd50000;
					1: v = 17'd20000;
					2: v = 17'd10000;
					3: v = 17'd5000;
					4: v = 17'd2000;
					5: v = 17'd1000;
					6: v = 17'd500;
					7: v = 17'd200;
					8: v = 17'd100;
					9: v = 17'd50;
					10: v = 17'd20;
					11: v = 17'd10;
					12: v = 17'd5;
					13: v = 17'd2;
					14: v = 17'd1;
					default: v = '0;
				endcase
			end
			return v;
		endfunction

		function int pending();
			return due_payouts.size();
		endfunction

		// greedy walk over the selected table, largest coin first
		function void note_amount(input logic [23:0] amount, input logic cur);
			int unsigned left;
			int unsigned d;
			int unsigned c;
			int          len;
			int          limit;
			int          first;
			payout_t     p;
			left  = 32'(amount);
			len   = (cur == CUR_USD) ? 14 : 15;
			limit = (NUM_DENOMS < len) ? NUM_DENOMS : len;
			first = due_payouts.size();
			for (int i = 0; i < limit && left != 0; i++) begin
				d = 32'(coin_value(cur, i));
				if (d != 0 && d <= left) begin
					c = left / d;
					left = left - c * d;
					p.denom = d[16:0];
					p.count = c[23:0];
					p.last  = 1'b0;
					due_payouts.push_back(p);
				end
			end
			if (due_payouts.size() > first)
				due_payouts[due_payouts.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(input string what);
			mismatch_count++;
			if (mismatch_count <= MAX_PRINTED)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_payout(input logic [16:0] denom, input logic [23:0] count,
				input logic last);
			payout_t want;
			if (due_payouts.size() == 0) begin
				report_mismatch($sformatf("unexpected payout denom=%0d count=%0d last=%0b",
					denom, count, last));
			end else begin
				want = due_payouts.pop_front();
				if (denom !== want.denom)
					report_mismatch($sformatf("denomination %0d, expected %0d",
						denom, want.denom));
				if (count !== want.count)
					report_mismatch($sformatf("count %0d, expected %0d (denom %0d)",
						count, want.count, want.denom));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b (denom %0d)",
						last, want.last, want.denom));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	payout_checker sb = new();
	logic          currency_now;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            cycle_count;

	logic [23:0] pln_cases[$] = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd50000, 24'd88888,
		24'd49999, 24'd0, 24'd16777215, 24'd16777214, 24'd250};
	logic [23:0] usd_cases[$] = '{24'd100000, 24'd138891, 24'd30, 24'd4, 24'd99999,
		24'd16777215, 24'd0, 24'd75};

	greedy_change_maker #(
		.NUM_DENOMS(NUM_DENOMS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// output side: check each transfer, then pick the next ready level
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_payout(m_tdata[16:0], m_tdata[40:17], m_tlast);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_amount(input logic [23:0] amount);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= amount;
		do @(posedge clk); while (!s_tready);
		sb.note_amount(amount, currency_now);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == REG_CURRENCY)
			currency_now = data[0];
		@(posedge clk);
	endtask

	task automatic check_currency_reg();
		logic [31:0] data;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= REG_CURRENCY;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		data = prdata;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (data[0] !== currency_now)
			sb.report_mismatch($sformatf("currency reads %0b, expected %0b",
				data[0], currency_now));
	endtask

	// no config write until the walk of the last amount has surely ended
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_amount();
		int pick;
		int len;
		pick = $urandom_range(99);
		len  = (currency_now == CUR_USD) ? 14 : 15;
		if (pick < 10)
			return 24'd0;
		else if (pick < 35)
			return 24'($urandom & 32'h00FF_FFFF);
		else if (pick < 65)
			return 24'($urandom_range(1, 999));
		else if (pick < 85)
			return 24'($urandom_range(1000, 300000));
		else
			return 24'(payout_checker::coin_value(currency_now, $urandom_range(0, len - 1))
				* $urandom_range(1, 5));
	endfunction

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		currency_now  = CUR_PLN;
		send_idle_pct = 20;
		recv_idle_pct = 70;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_currency_reg();
		foreach (pln_cases[i])
			send_amount(pln_cases[i]);
		settle();

		// only bit 0 of the written value counts
		write_reg(REG_CURRENCY, 32'hFFFF_FFFF);
		check_currency_reg();
		foreach (usd_cases[i])
			send_amount(usd_cases[i]);
		settle();

		// unmapped address: currency must stay USD
		write_reg(REG_UNMAPPED, 32'h0);
		check_currency_reg();
		send_amount(24'd138891);
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 70;
					write_reg(REG_CURRENCY, $urandom & 32'hFFFF_FFFE);
				end
				1: begin
					send_idle_pct = 70;
					recv_idle_pct = 20;
					write_reg(REG_CURRENCY, $urandom | 32'h1);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					write_reg(REG_CURRENCY, $urandom);
				end
			endcase
			check_currency_reg();
			repeat (RANDOM_ITEMS)
				send_amount(pick_amount());
			settle();
		end

		if (sb.mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/gcm_pkg.sv
hw/rtl/gcm_ctrl.sv
hw/rtl/gcm_dp.sv
hw/rtl/greedy_change_maker.sv
hw/rtl/gcm_checker.sv
tb/greedy_change_maker_tb.sv
